// ===== sv/ccts_pkg.sv =====
package ccts_pkg;

    localparam int CMD_W    = 2;
    localparam int CUR_W    = 16;
    localparam int CNT_W    = 6;
    localparam int POLL_W   = 8;
    localparam int SUM_W    = 22;
    localparam int RES_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POLL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    localparam logic [RES_W-1:0] RC_SUCC    = 2'd0;
    localparam logic [RES_W-1:0] RC_FAIL    = 2'd1;
    localparam logic [RES_W-1:0] RC_RUNNING = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_CURRENT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TOTAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR_FLOOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT    = 2'd3;

    localparam logic [CUR_W-1:0]  RST_MIN_CURRENT   = 16'd100;
    localparam logic [CNT_W-1:0]  RST_SAMPLE_TOTAL  = 6'd20;
    localparam logic [CNT_W-1:0]  RST_DIVISOR_FLOOR = 6'd10;
    localparam logic [POLL_W-1:0] RST_POLL_LIMIT    = 8'd50;

    typedef struct packed {
        logic [CUR_W-1:0]  min_current_ma;
        logic [CNT_W-1:0]  sample_total;
        logic [CNT_W-1:0]  divisor_floor;
        logic [POLL_W-1:0] ping_poll_limit;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== sv/ccts_if.sv =====
interface ccts_in_if;
    logic                       valid;
    logic                       ready;
    logic [ccts_pkg::CMD_W-1:0] cmd;
    logic                       ping_ready;
    logic [ccts_pkg::CUR_W-1:0] sample_ma;
    logic                       read_error;

    modport source (output valid, cmd, ping_ready, sample_ma, read_error, input ready);
    modport sink (input valid, cmd, ping_ready, sample_ma, read_error, output ready);
endinterface

interface ccts_out_if;
    logic                       valid;
    logic                       ready;
    logic [ccts_pkg::RES_W-1:0] result_code;
    logic                       busy_res;
    logic                       open_tx;
    logic                       tx_off;
    logic [ccts_pkg::CUR_W-1:0] avg_current_ma;
    logic                       done_res;

    modport source (output valid, result_code, busy_res, open_tx, tx_off, avg_current_ma,
                    done_res, input ready);
    modport sink (input valid, result_code, busy_res, open_tx, tx_off, avg_current_ma,
                  done_res, output ready);
endinterface

interface ccts_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ccts_pkg::CFG_IDX_W-1:0]  index;
    logic [ccts_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/ccts_cfg.sv =====
module ccts_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ccts_cfg_if.sink        i_cfg,
    output ccts_pkg::t_cfg  o_cfg
);
    import ccts_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_current_ma  <= RST_MIN_CURRENT;
            r_cfg.sample_total    <= RST_SAMPLE_TOTAL;
            r_cfg.divisor_floor   <= RST_DIVISOR_FLOOR;
            r_cfg.ping_poll_limit <= RST_POLL_LIMIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MIN_CURRENT:   r_cfg.min_current_ma  <= i_cfg.data;
                REG_SAMPLE_TOTAL:  r_cfg.sample_total    <= i_cfg.data[CNT_W-1:0];
                REG_DIVISOR_FLOOR: r_cfg.divisor_floor   <= i_cfg.data[CNT_W-1:0];
                REG_POLL_LIMIT:    r_cfg.ping_poll_limit <= i_cfg.data[POLL_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/ccts_div.sv =====
module ccts_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ccts_pkg::t_div_req i_req,
    output ccts_pkg::t_div_rsp o_rsp
);
    import ccts_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_fit;

    always_comb begin
        w_trial = {r_rem, r_q[SUM_W-1]};
        w_fit   = w_trial >= {1'b0, r_dvs};
        w_diff  = w_trial - {1'b0, r_dvs};
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_q   <= {r_q[SUM_W-2:0], w_fit};
        end
    end

endmodule

// ===== sv/coil_contact_test_sequencer_unit.sv =====
// Start, poll and most samples: result registered in the cycle after the transfer.
// For the last sample of a test the sum goes to a 22-step restoring divider, one bit a
// cycle, and the average is then registered. One item at a time: a new input is taken
// only while no division runs and the result register is free or being read.
// Reset (synchronous, active low) returns to idle, clears counters and the average,
// and loads the configuration registers with their defaults.
module coil_contact_test_sequencer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ccts_in_if.sink    i_in,
    ccts_out_if.source o_out,
    ccts_cfg_if.sink   i_cfg
);
    import ccts_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_PING, PH_SAMPLE} t_phase;
    typedef enum logic {S_RUN, S_DIV} t_ctl;

    t_cfg     w_cfg;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    t_ctl              r_ctl;
    t_phase            r_phase;
    t_phase            n_phase;
    logic [RES_W-1:0]  r_result;
    logic [RES_W-1:0]  n_result;
    logic [POLL_W-1:0] r_poll;
    logic [POLL_W-1:0] n_poll;
    logic [CNT_W-1:0]  r_scount;
    logic [CNT_W-1:0]  n_scount;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W-1:0]  n_div;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic [CUR_W-1:0]  r_avg;
    logic              r_out_valid;
    logic              r_o_busy;
    logic              r_o_open;
    logic              r_o_close;
    logic              r_o_done;
    logic              n_open;
    logic              n_close;
    logic              n_done;
    logic              n_need_div;
    logic [POLL_W-1:0] w_poll_inc;
    logic [CNT_W-1:0]  w_scount_inc;
    logic              w_low;
    logic              w_accept;
    logic [CUR_W-1:0]  w_avg;

    ccts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    ccts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign i_in.ready = (r_ctl == S_RUN) && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    assign o_out.valid          = r_out_valid;
    assign o_out.result_code    = r_result;
    assign o_out.busy_res       = r_o_busy;
    assign o_out.open_tx        = r_o_open;
    assign o_out.tx_off         = r_o_close;
    assign o_out.avg_current_ma = r_avg;
    assign o_out.done_res       = r_o_done;

    assign w_div_req.start    = w_accept && n_need_div;
    assign w_div_req.dividend = n_sum;
    assign w_div_req.divisor  = n_div;

    assign w_avg = (r_div == '0) ? '0 : w_div_rsp.quotient[CUR_W-1:0];

    always_comb begin
        n_phase    = r_phase;
        n_result   = r_result;
        n_poll     = r_poll;
        n_scount   = r_scount;
        n_div      = r_div;
        n_sum      = r_sum;
        n_open     = 1'b0;
        n_close    = 1'b0;
        n_done     = 1'b0;
        n_need_div = 1'b0;
        w_poll_inc   = r_poll + POLL_W'(1);
        w_scount_inc = r_scount + CNT_W'(1);
        w_low = (i_in.sample_ma < w_cfg.min_current_ma) && (r_div > w_cfg.divisor_floor);
        case (i_in.cmd)
            CMD_START: begin
                if (r_phase == PH_IDLE) begin
                    n_phase = PH_PING;
                    n_poll  = '0;
                    n_open  = 1'b1;
                end else begin
                    n_result = RC_RUNNING;
                end
            end
            CMD_POLL: begin
                if (r_phase == PH_PING) begin
                    if (i_in.ping_ready) begin
                        n_phase  = PH_SAMPLE;
                        n_scount = '0;
                        n_div    = w_cfg.sample_total;
                        n_sum    = '0;
                    end else begin
                        n_poll = w_poll_inc;
                        if (w_poll_inc >= w_cfg.ping_poll_limit) begin
                            n_result = RC_FAIL;
                            n_phase  = PH_IDLE;
                            n_done   = 1'b1;
                        end
                    end
                end
            end
            CMD_SAMPLE: begin
                if (r_phase == PH_SAMPLE) begin
                    if (i_in.read_error) begin
                        n_result = RC_FAIL;
                        n_phase  = PH_IDLE;
                        n_close  = 1'b1;
                        n_done   = 1'b1;
                    end else begin
                        if (w_low) begin
                            n_div = r_div - CNT_W'(1);
                        end else begin
                            n_sum = r_sum + SUM_W'(i_in.sample_ma);
                        end
                        n_scount = w_scount_inc;
                        if (w_scount_inc >= w_cfg.sample_total) begin
                            n_phase    = PH_IDLE;
                            n_close    = 1'b1;
                            n_done     = 1'b1;
                            n_need_div = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= S_RUN;
            r_phase     <= PH_IDLE;
            r_result    <= RC_SUCC;
            r_poll      <= '0;
            r_scount    <= '0;
            r_div       <= '0;
            r_sum       <= '0;
            r_avg       <= '0;
            r_out_valid <= 1'b0;
            r_o_busy    <= 1'b0;
            r_o_open    <= 1'b0;
            r_o_close   <= 1'b0;
            r_o_done    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase   <= n_phase;
                r_result  <= n_result;
                r_poll    <= n_poll;
                r_scount  <= n_scount;
                r_div     <= n_div;
                r_sum     <= n_sum;
                r_o_busy  <= (n_phase != PH_IDLE);
                r_o_open  <= n_open;
                r_o_close <= n_close;
                r_o_done  <= n_done;
                if (n_need_div) begin
                    r_ctl       <= S_DIV;
                    r_out_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_ctl == S_DIV && w_div_rsp.done) begin
                r_avg       <= w_avg;
                r_result    <= (w_avg >= w_cfg.min_current_ma) ? RC_SUCC : RC_FAIL;
                r_out_valid <= 1'b1;
                r_ctl       <= S_RUN;
            end
        end
    end

endmodule

// ===== verif/coil_contact_test_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps

module coil_contact_test_sequencer_unit_tb;
    import ccts_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 30;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_ITEMS    = 165;

    typedef enum logic [1:0] {TEST_IDLE, TEST_PING_WAIT, TEST_SAMPLING} t_test_phase;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             ping_ready;
        logic [CUR_W-1:0] sample_ma;
        logic             read_error;
    } t_command;

    typedef struct packed {
        logic [RES_W-1:0] result_code;
        logic             busy_res;
        logic             open_tx;
        logic             tx_off;
        logic [CUR_W-1:0] avg_current_ma;
        logic             done_res;
    } t_report;

    class contact_test_tracker;
        t_cfg              settings;
        t_test_phase       test_phase;
        logic [RES_W-1:0]  verdict;
        logic [POLL_W-1:0] polls;
        logic [CNT_W-1:0]  samples_taken;
        logic [CNT_W-1:0]  divisor;
        logic [SUM_W-1:0]  current_sum;
        logic [CUR_W-1:0]  average;
        t_report           expected_reports[$];
        int                failures;

        function new();
            settings = '{RST_MIN_CURRENT, RST_SAMPLE_TOTAL, RST_DIVISOR_FLOOR, RST_POLL_LIMIT};
            test_phase    = TEST_IDLE;
            verdict       = RC_SUCC;
            polls         = '0;
            samples_taken = '0;
            divisor       = '0;
            current_sum   = '0;
            average       = '0;
            failures      = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_MIN_CURRENT:   settings.min_current_ma  = data;
                REG_SAMPLE_TOTAL:  settings.sample_total    = data[CNT_W-1:0];
                REG_DIVISOR_FLOOR: settings.divisor_floor   = data[CNT_W-1:0];
                REG_POLL_LIMIT:    settings.ping_poll_limit = data[POLL_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_command(t_command c);
            t_report          r;
            logic [SUM_W-1:0] quotient;
            r = '0;
            case (c.cmd)
                CMD_START: begin
                    if (test_phase == TEST_IDLE) begin
                        test_phase = TEST_PING_WAIT;
                        polls      = '0;
                        r.open_tx  = 1'b1;
                    end else begin
                        verdict = RC_RUNNING;
                    end
                end
                CMD_POLL: begin
                    if (test_phase == TEST_PING_WAIT) begin
                        if (c.ping_ready) begin
                            test_phase    = TEST_SAMPLING;
                            samples_taken = '0;
                            divisor       = settings.sample_total;
                            current_sum   = '0;
                        end else begin
                            polls = polls + 1'b1;
                            if (polls >= settings.ping_poll_limit) begin
                                verdict    = RC_FAIL;
                                test_phase = TEST_IDLE;
                                r.done_res = 1'b1;
                            end
                        end
                    end
                end
                CMD_SAMPLE: begin
                    if (test_phase == TEST_SAMPLING) begin
                        if (c.read_error) begin
                            verdict    = RC_FAIL;
                            test_phase = TEST_IDLE;
                            r.tx_off   = 1'b1;
                            r.done_res = 1'b1;
                        end else begin
                            if (c.sample_ma < settings.min_current_ma &&
                                divisor > settings.divisor_floor) begin
                                divisor = divisor - 1'b1;
                            end else begin
                                current_sum = current_sum + SUM_W'(c.sample_ma);
                            end
                            samples_taken = samples_taken + 1'b1;
                            if (samples_taken >= settings.sample_total) begin
                                quotient   = (divisor != '0) ? current_sum / divisor : '0;
                                average    = quotient[CUR_W-1:0];
                                verdict    = (average >= settings.min_current_ma) ? RC_SUCC
                                                                                  : RC_FAIL;
                                test_phase = TEST_IDLE;
                                r.tx_off   = 1'b1;
                                r.done_res = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.result_code    = verdict;
            r.busy_res       = (test_phase != TEST_IDLE);
            r.avg_current_ma = average;
            expected_reports.push_back(r);
        endfunction

        function void compare_field(string field, logic [CUR_W-1:0] want, logic [CUR_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_report(t_report got);
            t_report want;
            if (expected_reports.size() == 0) begin
                $error("result_code: expected no transfer, got %0d", got.result_code);
                failures++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("result_code", CUR_W'(want.result_code), CUR_W'(got.result_code));
            compare_field("busy_res", CUR_W'(want.busy_res), CUR_W'(got.busy_res));
            compare_field("open_tx", CUR_W'(want.open_tx), CUR_W'(got.open_tx));
            compare_field("tx_off", CUR_W'(want.tx_off), CUR_W'(got.tx_off));
            compare_field("avg_current_ma", want.avg_current_ma, got.avg_current_ma);
            compare_field("done_res", CUR_W'(want.done_res), CUR_W'(got.done_res));
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ccts_in_if  in_ch();
    ccts_out_if out_ch();
    ccts_cfg_if cfg_ch();

    contact_test_tracker tracker = new();

    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;
    bit hold_request    = 1'b0;
    int test_items      = 0;

    coil_contact_test_sequencer_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                tracker.check_report(t_report'{out_ch.result_code, out_ch.busy_res,
                                               out_ch.open_tx, out_ch.tx_off,
                                               out_ch.avg_current_ma, out_ch.done_res});
            end
            if (in_ch.valid && in_ch.ready) begin
                tracker.take_command(t_command'{in_ch.cmd, in_ch.ping_ready,
                                                in_ch.sample_ma, in_ch.read_error});
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                tracker.write_register(cfg_ch.index, cfg_ch.data);
            end
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_ch.ready <= receiver_steady || ($urandom_range(0, 99) >= 18);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("coil_contact_test_sequencer_unit test failed");
        $finish;
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [CUR_W-1:0] rand_current();
        return CUR_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic ping_ready,
                             input logic [CUR_W-1:0] sample_ma, input logic read_error,
                             input bit counted);
        if (!sender_steady && $urandom_range(0, 99) < 18) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.ping_ready <= ping_ready;
        in_ch.sample_ma  <= sample_ma;
        in_ch.read_error <= read_error;
        do @(posedge i_clk); while (!in_ch.ready);
        if (counted) test_items++;
    endtask

    task automatic send_noise();
        send_item(CMD_W'($urandom_range(0, 3)), rand_bit(), rand_current(), rand_bit(), 1'b0);
    endtask

    function automatic logic [CUR_W-1:0] pick_sample();
        logic [CUR_W-1:0] level;
        level = tracker.settings.min_current_ma;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return level - 1'b1;
            3: return level;
            4: return level + 1'b1;
            5: return rand_current();
            default: return CUR_W'(level + $urandom_range(0, 255) - 16'd128);
        endcase
    endfunction

    task automatic run_contact_test();
        int path;
        int waits;
        int count;
        int limit;
        path  = $urandom_range(0, 99);
        limit = int'(tracker.settings.ping_poll_limit);
        send_item(CMD_START, rand_bit(), rand_current(), rand_bit(), 1'b1);
        if (path < 12) begin
            repeat ((limit == 0) ? 1 : limit) begin
                if ($urandom_range(0, 99) < 4) send_noise();
                send_item(CMD_POLL, 1'b0, rand_current(), rand_bit(), 1'b1);
            end
        end else begin
            waits = (limit <= 1) ? 0 : $urandom_range(0, (limit > 4) ? 3 : limit - 1);
            repeat (waits) begin
                send_item(CMD_POLL, 1'b0, rand_current(), rand_bit(), 1'b1);
            end
            send_item(CMD_POLL, 1'b1, rand_current(), rand_bit(), 1'b1);
            count = int'(tracker.settings.sample_total);
            // drop out early now and then, leaving the test open
            if (path >= 95) count = $urandom_range(0, count);
            repeat (count) begin
                if ($urandom_range(0, 99) < 4) send_noise();
                send_item(CMD_SAMPLE, rand_bit(), pick_sample(),
                          $urandom_range(0, 99) < 2, 1'b1);
            end
        end
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    task automatic apply_settings(input t_cfg s);
        logic [CFG_IDX_W-1:0]  order[4] = '{REG_MIN_CURRENT, REG_SAMPLE_TOTAL,
                                            REG_DIVISOR_FLOOR, REG_POLL_LIMIT};
        logic [CFG_DATA_W-1:0] values[4];
        values[0] = s.min_current_ma;
        values[1] = CFG_DATA_W'(s.sample_total);
        values[2] = CFG_DATA_W'(s.divisor_floor);
        values[3] = CFG_DATA_W'(s.ping_poll_limit);
        foreach (order[k]) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= order[k];
            cfg_ch.data  <= values[k];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        t_cfg s;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = CMD_NOP;
        in_ch.ping_ready = 1'b0;
        in_ch.sample_ma  = '0;
        in_ch.read_error = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_MIN_CURRENT;
        cfg_ch.data      = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        settle();
        apply_settings(t_cfg'{16'd100, 6'd3, 6'd2, 8'd2});
        send_item(CMD_POLL, 1'b1, 16'd0, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 16'hFFFF, 1'b1, 1'b0);
        send_item(CMD_NOP, 1'b1, 16'h5A5A, 1'b1, 1'b0);
        send_item(CMD_START, 1'b0, 16'd0, 1'b0, 1'b0);
        send_item(CMD_START, 1'b1, 16'hFFFF, 1'b1, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 16'd200, 1'b0, 1'b0);
        send_item(CMD_POLL, 1'b0, 16'd0, 1'b0, 1'b0);
        send_item(CMD_POLL, 1'b1, 16'd0, 1'b0, 1'b0);
        send_item(CMD_POLL, 1'b1, 16'd0, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 16'd0, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 16'hFFFF, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 16'd100, 1'b0, 1'b0);
        send_item(CMD_START, 1'b0, 16'd0, 1'b0, 1'b0);
        send_item(CMD_POLL, 1'b0, 16'd0, 1'b0, 1'b0);
        send_item(CMD_POLL, 1'b0, 16'd0, 1'b0, 1'b0);
        send_item(CMD_START, 1'b0, 16'd0, 1'b0, 1'b0);
        send_item(CMD_POLL, 1'b1, 16'd0, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 16'hFFFF, 1'b1, 1'b0);

        settle();
        apply_settings(t_cfg'{16'd100, 6'd0, 6'd0, 8'd0});
        send_item(CMD_START, 1'b0, 16'd0, 1'b0, 1'b0);
        send_item(CMD_POLL, 1'b0, 16'd0, 1'b0, 1'b0);
        send_item(CMD_START, 1'b0, 16'd0, 1'b0, 1'b0);
        send_item(CMD_POLL, 1'b1, 16'd0, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 16'd500, 1'b0, 1'b0);
        send_item(CMD_START, 1'b0, 16'd0, 1'b0, 1'b0);
        send_item(CMD_POLL, 1'b1, 16'd0, 1'b0, 1'b0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: s = t_cfg'{16'd100, 6'd4, 6'd2, 8'd3};
                1: s = t_cfg'{16'd0, 6'd1, 6'd1, 8'd1};
                2: s = t_cfg'{16'hFFFF, 6'd63, 6'd63, 8'd255};
                3: s = t_cfg'{16'd1000, 6'd63, 6'd1, 8'd4};
                default: begin
                    s.min_current_ma  = ($urandom_range(0, 3) == 0)
                                        ? rand_current()
                                        : CUR_W'($urandom_range(0, 3000));
                    s.sample_total    = CNT_W'($urandom_range(1, 10));
                    s.divisor_floor   = CNT_W'($urandom_range(1, 8));
                    s.ping_poll_limit = POLL_W'($urandom_range(1, 8));
                end
            endcase
            settle();
            apply_settings(s);
            sender_steady   = (p == 4);
            receiver_steady = (p == 4);
            // hold the result side off while items keep coming
            if (p == 1) hold_request = 1'b1;
            while (test_items < PHASE_ITEMS * (p + 1)) begin
                repeat ($urandom_range(0, 1)) send_noise();
                run_contact_test();
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending() == 0) begin
            $display("coil_contact_test_sequencer_unit test passed");
        end else begin
            $display("coil_contact_test_sequencer_unit test failed");
        end
        $finish;
    end

endmodule
